/* rtl/mrh_pkg.sv */
// ---------------------------------------------------------------------------
// mrh_pkg
// Shared types and constants for the row version history block.
// ---------------------------------------------------------------------------
package mrh_pkg;

  localparam int unsigned VersionDepth = 16;
  localparam int unsigned TimeWidth    = 32;
  localparam int unsigned WordWidth    = 32;
  localparam int unsigned IdxWidth     = (VersionDepth > 1) ? $clog2(VersionDepth) : 1;
  localparam int unsigned CntWidth     = $clog2(VersionDepth + 1);

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_NOTE   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_STALE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the transaction and compare against stored times
    logic execute;  // resolve lookup, perform write or read note
  } mrh_ctl_t;

endpackage

/* rtl/mrh_ctrl.sv */
// ---------------------------------------------------------------------------
// mrh_ctrl
// Two-state sequencer: accept a transaction, then execute it and raise the
// result strobe on the following cycle.
// ---------------------------------------------------------------------------
module mrh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output logic              done_o,
  output mrh_pkg::mrh_ctl_t ctl_o
);
  import mrh_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;
  logic done_q, done_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) state_d = StExec;
      end
      StExec: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign done_d = (state_q == StExec);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o        = (state_q == StExec);
  assign done_o        = done_q;
  assign ctl_o.capture = start_i && (state_q == StIdle);
  assign ctl_o.execute = (state_q == StExec);

endmodule

/* rtl/mrh_datapath.sv */
// ---------------------------------------------------------------------------
// mrh_datapath
// Version store, parallel timestamp compare, write and read-note logic,
// and the result registers.
// ---------------------------------------------------------------------------
module mrh_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mrh_pkg::mrh_ctl_t             ctl_i,
  input  logic [1:0]                    command_i,
  input  logic [mrh_pkg::TimeWidth-1:0] timestamp_i,
  input  logic [mrh_pkg::WordWidth-1:0] value_i,
  output logic                          found_o,
  output logic [mrh_pkg::WordWidth-1:0] value_out_o,
  output logic [1:0]                    status_o,
  output logic [mrh_pkg::TimeWidth-1:0] max_read_time_o,
  output logic [mrh_pkg::TimeWidth-1:0] max_write_time_o
);
  import mrh_pkg::*;

  // Version store, undefined until written; only entries below count are used
  logic [TimeWidth-1:0] times_q [VersionDepth];
  logic [WordWidth-1:0] words_q [VersionDepth];
  logic                 live_q  [VersionDepth];

  logic [CntWidth-1:0]  count_q, count_d;
  logic [TimeWidth-1:0] newest_read_q, newest_read_d;
  logic [TimeWidth-1:0] newest_write_q, newest_write_d;

  // Captured transaction
  logic [1:0]             cmd_q;
  logic [TimeWidth-1:0]   ts_q;
  logic [WordWidth-1:0]   val_q;
  logic [VersionDepth-1:0] hit_q, hit_d;

  // Result registers
  logic                 found_q, found_d;
  logic [WordWidth-1:0] vout_q, vout_d;
  logic [1:0]           status_q, status_d;

  logic                is_write, stale, full, do_write;
  logic [IdxWidth-1:0] sel;
  logic                any_hit;

  // Compare every stored time against the incoming timestamp
  always_comb begin
    for (int i = 0; i < VersionDepth; i++) begin
      hit_d[i] = (CntWidth'(i) < count_q) && (times_q[i] <= timestamp_i);
    end
  end

  // History is sorted, so hits form a prefix; pick its last entry
  always_comb begin
    sel = '0;
    for (int i = 0; i < VersionDepth; i++) begin
      if (hit_q[i] && ((i == VersionDepth - 1) || !hit_q[(i + 1) % VersionDepth])) begin
        sel = IdxWidth'(i);
      end
    end
  end

  assign any_hit  = |hit_q;
  assign is_write = (cmd_q == CMD_INSERT) || (cmd_q == CMD_DELETE);
  assign stale    = (ts_q <= newest_write_q);
  assign full     = (count_q == CntWidth'(VersionDepth));
  assign do_write = ctl_i.execute && is_write && !stale && !full;

  always_comb begin
    found_d        = 1'b0;
    vout_d         = '0;
    status_d       = ST_OK;
    count_d        = count_q;
    newest_read_d  = newest_read_q;
    newest_write_d = newest_write_q;
    unique case (cmd_q)
      CMD_LOOKUP: begin
        if (any_hit && live_q[sel]) begin
          found_d = 1'b1;
          vout_d  = words_q[sel];
        end
      end
      CMD_INSERT, CMD_DELETE: begin
        priority if (stale) begin
          status_d = ST_STALE;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d        = count_q + CntWidth'(1);
          newest_write_d = ts_q;
        end
      end
      CMD_NOTE: begin
        if (ts_q > newest_read_q) newest_read_d = ts_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      newest_read_q  <= '0;
      newest_write_q <= '0;
    end else if (ctl_i.execute) begin
      count_q        <= count_d;
      newest_read_q  <= newest_read_d;
      newest_write_q <= newest_write_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q <= command_i;
      ts_q  <= timestamp_i;
      val_q <= value_i;
      hit_q <= hit_d;
    end
    if (ctl_i.execute) begin
      found_q  <= found_d;
      vout_q   <= vout_d;
      status_q <= status_d;
    end
    if (do_write) begin
      times_q[count_q[IdxWidth-1:0]] <= ts_q;
      words_q[count_q[IdxWidth-1:0]] <= (cmd_q == CMD_INSERT) ? val_q : '0;
      live_q[count_q[IdxWidth-1:0]]  <= (cmd_q == CMD_INSERT);
    end
  end

  assign found_o          = found_q;
  assign value_out_o      = vout_q;
  assign status_o         = status_q;
  assign max_read_time_o  = newest_read_q;
  assign max_write_time_o = newest_write_q;

  ap_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntWidth'(VersionDepth))
    else $error("version count above depth");

  ap_write_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_write |=> (count_q == $past(count_q) + CntWidth'(1)) && (newest_write_q == $past(ts_q)))
    else $error("accepted write did not append");

  ap_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_write |-> !full && (ts_q > newest_write_q))
    else $error("write performed on full history or stale timestamp");

endmodule

/* rtl/multiversion_row_history.sv */
// ---------------------------------------------------------------------------
// multiversion_row_history
// Version history of one row: timestamped inserts and deletes, point-in-time
// lookups and read-timestamp tracking.
// ---------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high while busy is low; command_i,
//   timestamp_i and value_i are sampled at that edge. Commands: lookup,
//   insert value, delete, note read timestamp.
//   The accepting edge also compares timestamp_i against all stored versions
//   in parallel. The next cycle (busy high) resolves the lookup or performs
//   the write / read note and loads the result registers. The result appears
//   in the cycle after that, with done_o high for exactly one cycle.
//   A new transaction cannot be taken while busy is high; busy is low during
//   the done_o cycle, so the next start may be taken there. The receiver
//   cannot stall: results must be taken in the done_o cycle.
//   Reset clears the version count and both maximum timestamps; stored
//   versions need no clearing since only entries below the count are used.
// ---------------------------------------------------------------------------
module multiversion_row_history (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  output logic                          done_o,
  input  logic [1:0]                    command_i,
  input  logic [mrh_pkg::TimeWidth-1:0] timestamp_i,
  input  logic [mrh_pkg::WordWidth-1:0] value_i,
  output logic                          found_o,
  output logic [mrh_pkg::WordWidth-1:0] value_out_o,
  output logic [1:0]                    status_o,
  output logic [mrh_pkg::TimeWidth-1:0] max_read_time_o,
  output logic [mrh_pkg::TimeWidth-1:0] max_write_time_o
);
  import mrh_pkg::*;

  mrh_ctl_t ctl;

  mrh_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .ctl_o   (ctl)
  );

  mrh_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .command_i        (command_i),
    .timestamp_i      (timestamp_i),
    .value_i          (value_i),
    .found_o          (found_o),
    .value_out_o      (value_out_o),
    .status_o         (status_o),
    .max_read_time_o  (max_read_time_o),
    .max_write_time_o (max_write_time_o)
  );

  ap_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start execution");

  ap_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> done_o && !busy)
    else $error("execution not followed by result strobe");

  ap_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> (status_o == ST_OK))
    else $error("found lookup carries non-ok status");

endmodule
